// ----- sv/fctg_pkg.sv -----
package fctg_pkg;

  localparam int unsigned SCREEN_WIDTH  = 1024;
  localparam int unsigned SCREEN_HEIGHT = 768;
  localparam int unsigned TEXTURE_SIZE  = 64;

  localparam int unsigned HALF_HEIGHT = SCREEN_HEIGHT / 2;
  localparam int unsigned TEX_LOG2    = $clog2(TEXTURE_SIZE);

  localparam int unsigned COORD_W = 10;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned DEPTH_W = 24;
  localparam int unsigned TEX_W   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // row distance numerator (H/2) << 16 and its serial quotient
  localparam int unsigned NUM_W  = $clog2(HALF_HEIGHT + 1) + 16;
  localparam int unsigned QUO_W  = NUM_W;
  localparam int unsigned REL_W  = COORD_W;
  localparam int unsigned DCNT_W = $clog2(QUO_W + 1);
  localparam int unsigned OP_W   = DIR_W + 1;
  localparam int unsigned PROD_W = QUO_W + 1 + OP_W;

  // floor(d * 2 * plane / (W * 4096)) == (d * plane) >>> (log2(W) + 11)
  localparam int unsigned STEP_SHIFT  = $clog2(SCREEN_WIDTH) + 11;
  localparam int unsigned FLOOR_SHIFT = 12;

  localparam logic [NUM_W-1:0] NUMERATOR = NUM_W'(HALF_HEIGHT) << 16;

  localparam logic [DIR_W-1:0]   VIEW_DIR_X_RST = 16'd4096;
  localparam logic [DIR_W-1:0]   PLANE_Y_RST    = 16'd2703;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX_RST  = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_POS_X  = 3'd0,
    REG_CAM_POS_Y  = 3'd1,
    REG_VIEW_DIR_X = 3'd2,
    REG_VIEW_DIR_Y = 3'd3,
    REG_PLANE_X    = 3'd4,
    REG_PLANE_Y    = 3'd5,
    REG_DEPTH_MIN  = 3'd6,
    REG_DEPTH_MAX  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MUL_STEP_X  = 2'd0,
    MUL_STEP_Y  = 2'd1,
    MUL_FLOOR_X = 2'd2,
    MUL_FLOOR_Y = 2'd3
  } mul_sel_e;

  localparam int unsigned MUL_CNT_W = 3;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = 3'd4;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     prod_en;
    mul_sel_e prod_sel;
    logic     wr_en;
    mul_sel_e wr_sel;
    logic     emit;
    logic     use_latched;
  } fctg_cmd_t;

  typedef struct packed {
    logic setup_need;
    logic div_done;
    logic out_free;
  } fctg_sts_t;

  function automatic logic [TEX_W-1:0] texel_of(input logic [POS_W-1:0] pos);
    logic [31:0] t;
    t = ({16'd0, pos[15:0]} << TEX_LOG2) >> 16;
    return t[TEX_W-1:0];
  endfunction

endpackage

// ----- sv/fctg_div.sv -----
module fctg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fctg_pkg::REL_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [fctg_pkg::QUO_W-1:0]  quotient_o
);

  logic [fctg_pkg::REL_W-1:0]  rem_q, rem_d;
  logic [fctg_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic [fctg_pkg::REL_W-1:0]  div_q;
  logic [fctg_pkg::DCNT_W-1:0] cnt_q;
  logic                        done_q;
  logic [fctg_pkg::REL_W:0]    rem_sh;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[fctg_pkg::QUO_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_d  = ge ? fctg_pkg::REL_W'(rem_sh - {1'b0, div_q}) : rem_sh[fctg_pkg::REL_W-1:0];
    quo_d  = {quo_q[fctg_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == fctg_pkg::DCNT_W'(1));
      if (start_i) begin
        cnt_q <= fctg_pkg::DCNT_W'(fctg_pkg::QUO_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - fctg_pkg::DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= fctg_pkg::NUMERATOR;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/fctg_dp.sv -----
module fctg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fctg_pkg::fctg_cmd_t               cmd_i,
  output fctg_pkg::fctg_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [fctg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fctg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [fctg_pkg::COORD_W-1:0]      row_i,
  input  logic [fctg_pkg::COORD_W-1:0]      col_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic                              valid_res_o,
  output logic [fctg_pkg::TEX_W-1:0]        texel_u_o,
  output logic [fctg_pkg::TEX_W-1:0]        texel_v_o,
  output logic [fctg_pkg::DEPTH_W-1:0]      depth_o,
  output logic [fctg_pkg::COORD_W-1:0]      out_col_o,
  output logic [fctg_pkg::COORD_W-1:0]      out_row_o
);

  logic [fctg_pkg::POS_W-1:0]   cam_x_q, cam_y_q;
  logic [fctg_pkg::DIR_W-1:0]   dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [fctg_pkg::DEPTH_W-1:0] dmin_q, dmax_q;

  logic [fctg_pkg::POS_W-1:0]   floor_x_q, floor_y_q, step_x_q, step_y_q;
  logic [fctg_pkg::DEPTH_W-1:0] row_depth_q;

  logic [fctg_pkg::COORD_W-1:0] row_q, col_q;
  logic [fctg_pkg::COORD_W-1:0] item_row, item_col;
  logic                         item_below;

  logic                         div_done;
  logic [fctg_pkg::QUO_W-1:0]   quotient;
  logic [fctg_pkg::REL_W-1:0]   rel;

  logic signed [fctg_pkg::OP_W-1:0]   op;
  logic signed [fctg_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [fctg_pkg::PROD_W-1:0] step_sh, floor_sh;

  logic [fctg_pkg::QUO_W:0]     dm_lo, dm_hi;
  logic [fctg_pkg::DEPTH_W-1:0] dm_clamped;

  logic                         out_valid_q;
  logic                         valid_res_q;
  logic [fctg_pkg::TEX_W-1:0]   texel_u_q, texel_v_q;
  logic [fctg_pkg::DEPTH_W-1:0] depth_q;
  logic [fctg_pkg::COORD_W-1:0] out_col_q, out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      dir_x_q   <= fctg_pkg::VIEW_DIR_X_RST;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= fctg_pkg::PLANE_Y_RST;
      dmin_q    <= '0;
      dmax_q    <= fctg_pkg::DEPTH_MAX_RST;
    end else if (cfg_we_i) begin
      case (fctg_pkg::cfg_reg_e'(cfg_index_i))
        fctg_pkg::REG_CAM_POS_X:  cam_x_q   <= cfg_data_i;
        fctg_pkg::REG_CAM_POS_Y:  cam_y_q   <= cfg_data_i;
        fctg_pkg::REG_VIEW_DIR_X: dir_x_q   <= cfg_data_i[fctg_pkg::DIR_W-1:0];
        fctg_pkg::REG_VIEW_DIR_Y: dir_y_q   <= cfg_data_i[fctg_pkg::DIR_W-1:0];
        fctg_pkg::REG_PLANE_X:    plane_x_q <= cfg_data_i[fctg_pkg::DIR_W-1:0];
        fctg_pkg::REG_PLANE_Y:    plane_y_q <= cfg_data_i[fctg_pkg::DIR_W-1:0];
        fctg_pkg::REG_DEPTH_MIN:  dmin_q    <= cfg_data_i[fctg_pkg::DEPTH_W-1:0];
        fctg_pkg::REG_DEPTH_MAX:  dmax_q    <= cfg_data_i[fctg_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= row_i;
      col_q <= col_i;
    end
  end

  assign item_row   = cmd_i.use_latched ? row_q : row_i;
  assign item_col   = cmd_i.use_latched ? col_q : col_i;
  assign item_below = item_row > fctg_pkg::COORD_W'(fctg_pkg::HALF_HEIGHT);
  assign rel        = fctg_pkg::REL_W'(row_i - fctg_pkg::COORD_W'(fctg_pkg::HALF_HEIGHT));

  fctg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  (rel),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    case (cmd_i.prod_sel)
      fctg_pkg::MUL_STEP_X:  op = $signed({plane_x_q[fctg_pkg::DIR_W-1], plane_x_q});
      fctg_pkg::MUL_STEP_Y:  op = $signed({plane_y_q[fctg_pkg::DIR_W-1], plane_y_q});
      fctg_pkg::MUL_FLOOR_X: op = $signed({dir_x_q[fctg_pkg::DIR_W-1], dir_x_q})
                                - $signed({plane_x_q[fctg_pkg::DIR_W-1], plane_x_q});
      fctg_pkg::MUL_FLOOR_Y: op = $signed({dir_y_q[fctg_pkg::DIR_W-1], dir_y_q})
                                - $signed({plane_y_q[fctg_pkg::DIR_W-1], plane_y_q});
      default:               op = '0;
    endcase
    prod_d   = $signed({1'b0, quotient}) * op;
    step_sh  = prod_q >>> fctg_pkg::STEP_SHIFT;
    floor_sh = prod_q >>> fctg_pkg::FLOOR_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    dm_lo = (quotient < fctg_pkg::QUO_W'(dmin_q)) ? {1'b0, fctg_pkg::QUO_W'(dmin_q)}
                                                  : {1'b0, quotient};
    dm_hi = (dm_lo > (fctg_pkg::QUO_W + 1)'(dmax_q)) ? (fctg_pkg::QUO_W + 1)'(dmax_q) : dm_lo;
    dm_clamped = dm_hi[fctg_pkg::DEPTH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_x_q   <= '0;
      floor_y_q   <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      row_depth_q <= '0;
    end else begin
      if (div_done) begin
        row_depth_q <= dm_clamped;
      end
      if (cmd_i.wr_en) begin
        case (cmd_i.wr_sel)
          fctg_pkg::MUL_STEP_X:  step_x_q  <= step_sh[fctg_pkg::POS_W-1:0];
          fctg_pkg::MUL_STEP_Y:  step_y_q  <= step_sh[fctg_pkg::POS_W-1:0];
          fctg_pkg::MUL_FLOOR_X: floor_x_q <= cam_x_q + floor_sh[fctg_pkg::POS_W-1:0];
          fctg_pkg::MUL_FLOOR_Y: floor_y_q <= cam_y_q + floor_sh[fctg_pkg::POS_W-1:0];
          default: ;
        endcase
      end else if (cmd_i.emit && item_below) begin
        floor_x_q <= floor_x_q + step_x_q;
        floor_y_q <= floor_y_q + step_y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      valid_res_q <= item_below;
      texel_u_q   <= item_below ? fctg_pkg::texel_of(floor_x_q) : '0;
      texel_v_q   <= item_below ? fctg_pkg::texel_of(floor_y_q) : '0;
      depth_q     <= item_below ? row_depth_q : '0;
      out_col_q   <= item_col;
      out_row_q   <= item_row;
    end
  end

  assign sts_o.setup_need = (row_i > fctg_pkg::COORD_W'(fctg_pkg::HALF_HEIGHT))
                          && (col_i == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign texel_u_o   = texel_u_q;
  assign texel_v_o   = texel_v_q;
  assign depth_o     = depth_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;

endmodule

// ----- sv/fctg_ctrl.sv -----
module fctg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fctg_pkg::fctg_sts_t  sts_i,
  output fctg_pkg::fctg_cmd_t  cmd_o
);

  fctg_pkg::state_e                  state_q, state_d;
  logic [fctg_pkg::MUL_CNT_W-1:0]    cnt_q, cnt_d;
  logic [fctg_pkg::MUL_CNT_W-1:0]    cnt_m1;
  logic                              stall;
  logic                              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fctg_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cnt_m1  = cnt_q - fctg_pkg::MUL_CNT_W'(1);
    cmd_o   = '0;
    stall   = (state_q != fctg_pkg::ST_IDLE) || !sts_i.out_free;
    accept  = in_valid_i && !stall;
    case (state_q)
      fctg_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts_i.setup_need) begin
            cmd_o.capture   = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = fctg_pkg::ST_DIV;
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      fctg_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          cnt_d   = '0;
          state_d = fctg_pkg::ST_MUL;
        end
      end
      fctg_pkg::ST_MUL: begin
        cmd_o.prod_en  = cnt_q != fctg_pkg::MUL_LAST;
        cmd_o.prod_sel = fctg_pkg::mul_sel_e'(cnt_q[1:0]);
        cmd_o.wr_en    = cnt_q != '0;
        cmd_o.wr_sel   = fctg_pkg::mul_sel_e'(cnt_m1[1:0]);
        cnt_d          = cnt_q + fctg_pkg::MUL_CNT_W'(1);
        if (cnt_q == fctg_pkg::MUL_LAST) begin
          state_d = fctg_pkg::ST_EMIT;
        end
      end
      fctg_pkg::ST_EMIT: begin
        cmd_o.use_latched = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = fctg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fctg_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = stall;

endmodule

// ----- sv/floor_cast_texel_generator.sv -----
// Floor-casting texel generator.
// Input channel (in_valid_i / in_stall_o, row_i, col_i) takes one screen pixel per
// transfer, rows in order and columns of a row in order from zero. Output channel
// (out_valid_o / out_stall_i) returns one result per pixel: valid_res, texel u/v,
// clamped depth and the echoed coordinates.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high, write only while no pixel is in flight.
// Timing: a pixel that needs no row setup is registered into the output stage at its
// transfer and shows the cycle after, one pixel per cycle while the output is not
// stalled. Column zero of a row below the horizon starts a row setup: a radix-2 serial
// divider (one quotient bit per cycle, 25 quotient bits for 768 lines), a depth clamp,
// a single shared multiplier for the two steps and two start positions, then the output
// stage; the next transfer is taken only once the result is in the output stage, later
// while the output register is still stalled.
// Stall: the output register holds its result while out_stall_i is high; the input
// side stalls during a row setup and when a new result would have no place to go.
// Reset: camera registers return to their defaults, floor position, step and depth
// go to zero and the output stage empties.
module floor_cast_texel_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fctg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fctg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fctg_pkg::COORD_W-1:0]      row_i,
  input  logic [fctg_pkg::COORD_W-1:0]      col_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              valid_res_o,
  output logic [fctg_pkg::TEX_W-1:0]        texel_u_o,
  output logic [fctg_pkg::TEX_W-1:0]        texel_v_o,
  output logic [fctg_pkg::DEPTH_W-1:0]      depth_o,
  output logic [fctg_pkg::COORD_W-1:0]      out_col_o,
  output logic [fctg_pkg::COORD_W-1:0]      out_row_o
);

  fctg_pkg::fctg_cmd_t cmd;
  fctg_pkg::fctg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fctg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fctg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .valid_res_o (valid_res_o),
    .texel_u_o   (texel_u_o),
    .texel_v_o   (texel_v_o),
    .depth_o     (depth_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o)
  );

endmodule

// ----- sv/fctg_sva.sv -----
module fctg_sva (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [fctg_pkg::COORD_W-1:0]      row_i,
  input logic [fctg_pkg::COORD_W-1:0]      col_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              valid_res_o,
  input logic [fctg_pkg::TEX_W-1:0]        texel_u_o,
  input logic [fctg_pkg::TEX_W-1:0]        texel_v_o,
  input logic [fctg_pkg::DEPTH_W-1:0]      depth_o,
  input logic [fctg_pkg::COORD_W-1:0]      out_col_o,
  input logic [fctg_pkg::COORD_W-1:0]      out_row_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(row_i) && $stable(col_i))
    else $error("input transfer changed under stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(texel_u_o) && $stable(texel_v_o)
      && $stable(depth_o) && $stable(out_row_o) && $stable(out_col_o)
      && $stable(valid_res_o))
    else $error("output payload changed under stall");

  a_horizon_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> texel_u_o == '0 && texel_v_o == '0 && depth_o == '0)
    else $error("horizon result carries nonzero texel or depth");

  a_valid_res_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> valid_res_o
      == (out_row_o > fctg_pkg::COORD_W'(fctg_pkg::HALF_HEIGHT)))
    else $error("valid_res disagrees with result row");

endmodule

bind floor_cast_texel_generator fctg_sva u_fctg_sva (.*);

// ----- tb/floor_cast_texel_generator_test.sv -----
`timescale 1ns / 100ps

module floor_cast_texel_generator_test;

  typedef struct packed {
    logic                         valid_res;
    logic [fctg_pkg::TEX_W-1:0]   u;
    logic [fctg_pkg::TEX_W-1:0]   v;
    logic [fctg_pkg::DEPTH_W-1:0] depth;
    logic [fctg_pkg::COORD_W-1:0] col;
    logic [fctg_pkg::COORD_W-1:0] row;
  } texel_t;

  typedef enum logic {
    ENT_PIXEL,
    ENT_REG
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e                     kind;
    logic [fctg_pkg::COORD_W-1:0]    row;
    logic [fctg_pkg::COORD_W-1:0]    col;
    fctg_pkg::cfg_reg_e              idx;
    logic [fctg_pkg::CFG_DATA_W-1:0] data;
    logic                            typed;
    texel_t                          res;
  } plan_row_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [fctg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fctg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic [fctg_pkg::COORD_W-1:0]    row_in    = '0;
  logic [fctg_pkg::COORD_W-1:0]    col_in    = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            valid_res;
  logic [fctg_pkg::TEX_W-1:0]      texel_u;
  logic [fctg_pkg::TEX_W-1:0]      texel_v;
  logic [fctg_pkg::DEPTH_W-1:0]    depth;
  logic [fctg_pkg::COORD_W-1:0]    out_col;
  logic [fctg_pkg::COORD_W-1:0]    out_row;

  // camera registers as the block should hold them
  logic [fctg_pkg::POS_W-1:0]   cam_x = '0;
  logic [fctg_pkg::POS_W-1:0]   cam_y = '0;
  logic [fctg_pkg::DIR_W-1:0]   dir_x = fctg_pkg::VIEW_DIR_X_RST;
  logic [fctg_pkg::DIR_W-1:0]   dir_y = '0;
  logic [fctg_pkg::DIR_W-1:0]   pln_x = '0;
  logic [fctg_pkg::DIR_W-1:0]   pln_y = fctg_pkg::PLANE_Y_RST;
  logic [fctg_pkg::DEPTH_W-1:0] dmin  = '0;
  logic [fctg_pkg::DEPTH_W-1:0] dmax  = fctg_pkg::DEPTH_MAX_RST;

  // row walk state
  logic [fctg_pkg::POS_W-1:0]   fl_x = '0;
  logic [fctg_pkg::POS_W-1:0]   fl_y = '0;
  logic [fctg_pkg::POS_W-1:0]   st_x = '0;
  logic [fctg_pkg::POS_W-1:0]   st_y = '0;
  logic [fctg_pkg::DEPTH_W-1:0] row_depth_q = '0;

  texel_t texel_q[$];
  int     errors       = 0;
  int     pixels_sent  = 0;
  int     setups       = 0;
  int     horizon_hits = 0;
  int     reg_writes   = 0;
  int     send_idle    = 18;
  int     recv_idle    = 76;

  floor_cast_texel_generator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .row_i       (row_in),
    .col_i       (col_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .valid_res_o (valid_res),
    .texel_u_o   (texel_u),
    .texel_v_o   (texel_v),
    .depth_o     (depth),
    .out_col_o   (out_col),
    .out_row_o   (out_row)
  );

  always #4 clk = ~clk;

  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [fctg_pkg::TEX_W-1:0] frac_texel(
      input logic [fctg_pkg::POS_W-1:0] pos);
    logic [47:0] scaled;
    scaled = 48'(pos[15:0]) * fctg_pkg::TEXTURE_SIZE;
    return scaled[16 +: fctg_pkg::TEX_W];
  endfunction

  function automatic texel_t predict_texel(input logic [fctg_pkg::COORD_W-1:0] row,
                                           input logic [fctg_pkg::COORD_W-1:0] col);
    texel_t res;
    longint rel;
    longint row_dist;
    longint span;
    res     = '0;
    res.col = col;
    res.row = row;
    rel = longint'(row) - longint'(fctg_pkg::HALF_HEIGHT);
    if (rel <= 0) begin
      horizon_hits++;
      return res;
    end
    if (col == '0) begin
      setups++;
      row_dist = (longint'(fctg_pkg::HALF_HEIGHT) << 16) / rel;
      span     = longint'(fctg_pkg::SCREEN_WIDTH) * 4096;
      st_x = fctg_pkg::POS_W'(div_floor(row_dist * 2 * longint'($signed(pln_x)), span));
      st_y = fctg_pkg::POS_W'(div_floor(row_dist * 2 * longint'($signed(pln_y)), span));
      fl_x = cam_x + fctg_pkg::POS_W'(div_floor(row_dist *
             (longint'($signed(dir_x)) - longint'($signed(pln_x))), 4096));
      fl_y = cam_y + fctg_pkg::POS_W'(div_floor(row_dist *
             (longint'($signed(dir_y)) - longint'($signed(pln_y))), 4096));
      if (row_dist < longint'(dmin)) row_dist = longint'(dmin);
      if (row_dist > longint'(dmax)) row_dist = longint'(dmax);
      row_depth_q = fctg_pkg::DEPTH_W'(row_dist);
    end
    res.valid_res = 1'b1;
    res.u         = frac_texel(fl_x);
    res.v         = frac_texel(fl_y);
    res.depth     = row_depth_q;
    fl_x += st_x;
    fl_y += st_y;
    return res;
  endfunction

  function automatic plan_row_t pix(input int row, input int col);
    plan_row_t p;
    p      = '0;
    p.kind = ENT_PIXEL;
    p.row  = fctg_pkg::COORD_W'(row);
    p.col  = fctg_pkg::COORD_W'(col);
    return p;
  endfunction

  function automatic plan_row_t pix_known(input int row, input int col, input logic vr);
    plan_row_t p;
    p               = pix(row, col);
    p.typed         = 1'b1;
    p.res.valid_res = vr;
    p.res.row       = fctg_pkg::COORD_W'(row);
    p.res.col       = fctg_pkg::COORD_W'(col);
    return p;
  endfunction

  function automatic plan_row_t reg_row(input fctg_pkg::cfg_reg_e idx,
                                        input logic [fctg_pkg::CFG_DATA_W-1:0] data);
    plan_row_t p;
    p      = '0;
    p.kind = ENT_REG;
    p.idx  = idx;
    p.data = data;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // hold valid until the transfer; valid is left high for a following pixel
  task automatic send_pixel(input logic [fctg_pkg::COORD_W-1:0] row,
                            input logic [fctg_pkg::COORD_W-1:0] col,
                            input logic typed, input texel_t typed_res);
    texel_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    row_in   <= row;
    col_in   <= col;
    do @(posedge clk); while (in_stall);
    res = predict_texel(row, col);
    texel_q.push_back(typed ? typed_res : res);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(input fctg_pkg::cfg_reg_e idx,
                           input logic [fctg_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fctg_pkg::REG_CAM_POS_X:  cam_x = data;
      fctg_pkg::REG_CAM_POS_Y:  cam_y = data;
      fctg_pkg::REG_VIEW_DIR_X: dir_x = data[fctg_pkg::DIR_W-1:0];
      fctg_pkg::REG_VIEW_DIR_Y: dir_y = data[fctg_pkg::DIR_W-1:0];
      fctg_pkg::REG_PLANE_X:    pln_x = data[fctg_pkg::DIR_W-1:0];
      fctg_pkg::REG_PLANE_Y:    pln_y = data[fctg_pkg::DIR_W-1:0];
      fctg_pkg::REG_DEPTH_MIN:  dmin  = data[fctg_pkg::DEPTH_W-1:0];
      fctg_pkg::REG_DEPTH_MAX:  dmax  = data[fctg_pkg::DEPTH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_camera(input int mode);
    logic [fctg_pkg::CFG_DATA_W-1:0] v[8];
    for (int i = 0; i < 8; i++) v[i] = $urandom();
    case (mode)
      0: begin
        for (int i = 2; i < 6; i++) v[i][15:0] = 16'($urandom_range(16383) - 8192);
        v[6][23:0] = 24'($urandom_range(32'h20000));
        v[7][23:0] = 24'($urandom_range(32'hFFFFFF, 32'h10000));
      end
      1: begin
        v[0] = 32'h8000_0000;
        v[1] = 32'h8000_0000;
        v[2] = 32'h0000_8000;
        v[3] = 32'h0000_8000;
        v[4] = 32'h0000_7FFF;
        v[5] = 32'h0000_7FFF;
        v[6] = '0;
        v[7] = '0;
      end
      2: begin
        v[0] = 32'h7FFF_FFFF;
        v[1] = 32'h7FFF_FFFF;
        v[2] = 32'hFFFF_7FFF;
        v[3] = 32'hFFFF_7FFF;
        v[4] = 32'hFFFF_8000;
        v[5] = 32'hFFFF_8000;
        v[6] = 32'hFFFF_FFFF;
        v[7] = 32'hFFFF_FFFF;
      end
      4: begin
        v[0] = '0;
        v[1] = '0;
        v[2] = 32'(fctg_pkg::VIEW_DIR_X_RST);
        v[3] = '0;
        v[4] = '0;
        v[5] = 32'(fctg_pkg::PLANE_Y_RST);
      end
      default: ;
    endcase
    wait_drained();
    for (int i = 0; i < 8; i++) write_reg(fctg_pkg::cfg_reg_e'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_segment(input int quota);
    int                           n;
    int                           len;
    int                           pick;
    int                           start;
    logic [fctg_pkg::COORD_W-1:0] row;
    n = 0;
    while (n < quota) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        row = ($urandom_range(9) == 0)
            ? fctg_pkg::COORD_W'($urandom_range(fctg_pkg::HALF_HEIGHT))
            : fctg_pkg::COORD_W'($urandom_range(767, fctg_pkg::HALF_HEIGHT + 1));
        len = ($urandom_range(15) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
        for (int c = 0; c < len; c++) send_pixel(row, fctg_pkg::COORD_W'(c), 1'b0, '0);
      end else if (pick < 85) begin
        row   = fctg_pkg::COORD_W'($urandom_range(767, fctg_pkg::HALF_HEIGHT + 1));
        len   = $urandom_range(5, 1);
        start = $urandom_range(1023, 1);
        for (int c = 0; c < len; c++) begin
          send_pixel(row, fctg_pkg::COORD_W'(start + c), 1'b0, '0);
        end
      end else begin
        len = 1;
        send_pixel(fctg_pkg::COORD_W'($urandom_range(767)),
                   fctg_pkg::COORD_W'($urandom_range(1023)), 1'b0, '0);
      end
      n += len;
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin : check_results
    texel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (texel_q.size() == 0) begin
        report_mismatch("result with none pending, row", out_row, 0);
      end else begin
        want = texel_q.pop_front();
        if (valid_res !== want.valid_res) report_mismatch("valid_res", valid_res, want.valid_res);
        if (texel_u !== want.u)           report_mismatch("texel_u", texel_u, want.u);
        if (texel_v !== want.v)           report_mismatch("texel_v", texel_v, want.v);
        if (depth !== want.depth)         report_mismatch("depth", depth, want.depth);
        if (out_col !== want.col)         report_mismatch("out_col", out_col, want.col);
        if (out_row !== want.row)         report_mismatch("out_row", out_row, want.row);
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    plan.push_back(pix_known(500, 5, 1'b1));
    plan.push_back(pix_known(767, 1023, 1'b1));
    plan.push_back(pix_known(0, 0, 1'b0));
    plan.push_back(pix_known(384, 0, 1'b0));
    plan.push_back(pix_known(384, 1023, 1'b0));
    plan.push_back(pix(385, 0));
    plan.push_back(pix(385, 1));
    plan.push_back(pix(767, 0));
    plan.push_back(pix(767, 1));
    plan.push_back(pix_known(200, 0, 1'b0));
    plan.push_back(pix(767, 2));
    plan.push_back(pix(767, 1023));
    plan.push_back(pix(640, 0));
    plan.push_back(reg_row(fctg_pkg::REG_DEPTH_MIN, 32'h00FF_FFFF));
    plan.push_back(reg_row(fctg_pkg::REG_DEPTH_MAX, 32'h0000_0000));
    plan.push_back(pix(700, 0));
    plan.push_back(pix(700, 1));
    plan.push_back(reg_row(fctg_pkg::REG_CAM_POS_X, 32'h7FFF_FFFF));
    plan.push_back(reg_row(fctg_pkg::REG_CAM_POS_Y, 32'h8000_0000));
    plan.push_back(reg_row(fctg_pkg::REG_VIEW_DIR_X, 32'h0000_8000));
    plan.push_back(reg_row(fctg_pkg::REG_VIEW_DIR_Y, 32'h0000_7FFF));
    plan.push_back(reg_row(fctg_pkg::REG_PLANE_X, 32'h0000_7FFF));
    plan.push_back(reg_row(fctg_pkg::REG_PLANE_Y, 32'h0000_8000));
    plan.push_back(reg_row(fctg_pkg::REG_DEPTH_MAX, 32'h00FF_FFFF));
    plan.push_back(pix(385, 0));
    plan.push_back(pix(385, 1));
    plan.push_back(pix(767, 0));
    plan.push_back(pix(767, 512));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ENT_REG) begin
        if (i == 0 || plan[i-1].kind != ENT_REG) wait_drained();
        write_reg(plan[i].idx, plan[i].data);
        if (i == plan.size() - 1 || plan[i+1].kind != ENT_REG) cfg_valid <= 1'b0;
      end else begin
        send_pixel(plan[i].row, plan[i].col, plan[i].typed, plan[i].res);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 76 : 0;
      recv_idle = (ph == 0) ? 76 : (ph == 1) ? 18 : 0;
      for (int s = 0; s < 4; s++) begin
        program_camera((ph * 4 + s) % 5);
        run_segment(54);
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    $display("%0d pixels over %0d row setups, %0d at or above the horizon",
             pixels_sent, setups, horizon_hits);
    $display("%0d register writes across 12 camera settings and three idle patterns",
             reg_writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fctg_pkg.sv
sv/fctg_div.sv
sv/fctg_dp.sv
sv/fctg_ctrl.sv
sv/floor_cast_texel_generator.sv
sv/fctg_sva.sv
tb/floor_cast_texel_generator_test.sv
